>>> hw/rtl/twr_response_ranging_assert.svh
// ----------------------------------------------------------------------------
// Ranging assertion macros
// Concurrent checks on clk, with and without the synchronous reset as disable.
// ----------------------------------------------------------------------------
`ifndef TWR_RESPONSE_RANGING_ASSERT_SVH
`define TWR_RESPONSE_RANGING_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TWR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");
`define TWR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define TWR_ASSERT(label, prop)
`define TWR_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> hw/rtl/twr_pkg.sv
// ----------------------------------------------------------------------------
// Ranging package
// Shared widths, codes, register map and controller/datapath interface types.
// ----------------------------------------------------------------------------
package twr_pkg;

  localparam int FRAME_BYTES_DEF  = 20;
  localparam int HEADER_BYTES_DEF = 10;

  localparam int SEQ_POS      = 2;
  localparam int RX_STAMP_POS = 10;
  localparam int TX_STAMP_POS = 14;
  localparam int STAMP_BYTES  = 4;
  localparam int MIN_FRAME    = 18;

  localparam int BYTE_W    = 8;
  localparam int STAMP_W   = 32;
  localparam int INTEG_W   = 21;
  localparam int SEQ_W     = 8;
  localparam int FAIL_W    = 5;
  localparam int DIST_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int S_TDATA_W = 96;
  localparam int M_TDATA_W = 32;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  // shared multiplier and accumulators
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 90;
  localparam int DACC_W = 65;

  localparam logic signed [31:0] RATIO_GAIN_RST     = 32'shFD89F3F0;
  localparam logic        [31:0] DISTANCE_SCALE_RST = 32'd1007245000;
  localparam logic [FAIL_W-1:0]  MAX_ATTEMPTS_RST   = 5'd25;

  localparam logic [1:0] REG_RATIO_GAIN     = 2'd0;
  localparam logic [1:0] REG_DISTANCE_SCALE = 2'd1;
  localparam logic [1:0] REG_MAX_ATTEMPTS   = 2'd2;

  typedef enum logic {
    CMD_BYTE    = 1'b0,
    CMD_TIMEOUT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_DISTANCE = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_TIMEOUT  = 2'd2,
    STATUS_GAVE_UP  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_OK,
    KIND_MISMATCH,
    KIND_TIMEOUT
  } kind_t;

  typedef enum logic [2:0] {
    MUL_P,
    MUL_C0,
    MUL_C1,
    MUL_D0,
    MUL_D1,
    MUL_D2
  } mul_op_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_INIT,
    ACC_ADD_LO,
    ACC_ADD_HI,
    DACC_LOAD,
    DACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic signed [31:0] ratio_gain;
    logic        [31:0] distance_scale;
    logic [FAIL_W-1:0]  max_attempts;
  } cfg_t;

  typedef struct packed {
    logic    byte_we;
    mul_op_t mul_op;
    acc_op_t acc_op;
    logic    result_we;
    kind_t   kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_good;
  } dp_status_t;

  // response header, sequence byte shown as zero
  function automatic logic [BYTE_W-1:0] resp_header_byte(input logic [3:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      4'd0: b = 8'h41;
      4'd1: b = 8'h88;
      4'd2: b = 8'h00;
      4'd3: b = 8'hCA;
      4'd4: b = 8'hDE;
      4'd5: b = 8'h56;
      4'd6: b = 8'h45;
      4'd7: b = 8'h57;
      4'd8: b = 8'h41;
      4'd9: b = 8'hE1;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/twr_regs.sv
// ----------------------------------------------------------------------------
// Ranging configuration registers
// APB-style register file: ratio gain, distance scale, attempt limit.
// ----------------------------------------------------------------------------
module twr_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [twr_pkg::CFG_AW-1:0] paddr,
  input  logic [twr_pkg::CFG_DW-1:0] pwdata,
  output logic [twr_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output twr_pkg::cfg_t              cfg
);
  import twr_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ratio_gain     <= RATIO_GAIN_RST;
      cfg.distance_scale <= DISTANCE_SCALE_RST;
      cfg.max_attempts   <= MAX_ATTEMPTS_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_RATIO_GAIN:     cfg.ratio_gain     <= pwdata;
        REG_DISTANCE_SCALE: cfg.distance_scale <= pwdata;
        REG_MAX_ATTEMPTS:   cfg.max_attempts   <= pwdata[FAIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RATIO_GAIN:     prdata = cfg.ratio_gain;
      REG_DISTANCE_SCALE: prdata = cfg.distance_scale;
      REG_MAX_ATTEMPTS:   prdata = {{(CFG_DW-FAIL_W){1'b0}}, cfg.max_attempts};
      default:            prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/twr_dp.sv
// ----------------------------------------------------------------------------
// Ranging datapath
// Frame byte checker, stamp capture, shared 33x33 multiplier, accumulators,
// attempt bookkeeping and the result register.
// ----------------------------------------------------------------------------
module twr_dp #(
  parameter int FRAME_BYTES  = twr_pkg::FRAME_BYTES_DEF,
  parameter int HEADER_BYTES = twr_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  twr_pkg::cfg_t                 cfg,
  input  twr_pkg::ctrl_cmd_t            cmd,
  input  logic [twr_pkg::S_TDATA_W-1:0] in_data,
  output twr_pkg::dp_status_t           status,
  output logic [twr_pkg::M_TDATA_W-1:0] res_data,
  output logic [twr_pkg::STATUS_W-1:0]  res_status
);
  import twr_pkg::*;

  localparam int IDX_W = $clog2(FRAME_BYTES + 1);

  logic [BYTE_W-1:0]         rx_byte;
  logic [STAMP_W-1:0]        poll_tx_time;
  logic [STAMP_W-1:0]        resp_rx_time;
  logic signed [INTEG_W-1:0] carrier_integrator;

  logic [IDX_W-1:0]          byte_index;
  logic                      header_ok;
  logic                      overlong;
  logic [STAMP_W-1:0]        remote_rx_stamp;
  logic [STAMP_W-1:0]        remote_tx_stamp;
  logic [SEQ_W-1:0]          seq_counter;
  logic [FAIL_W-1:0]         fail_count;

  logic [STAMP_W-1:0]        ri;
  logic signed [INTEG_W-1:0] integ;
  logic [INTEG_W-1:0]        p_hi;
  logic [STAMP_W-1:0]        rr;
  logic [STAMP_W:0]          t;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]          acc;
  logic [DACC_W-1:0]         dacc;

  logic [FAIL_W-1:0]         fail_inc;
  logic                      give_up;
  logic [STATUS_W-1:0]       out_status;
  logic [DIST_W-1:0]         out_dist;
  logic                      out_clamped;
  logic [SEQ_W-1:0]          out_seq;

  assign rx_byte            = in_data[7:0];
  assign poll_tx_time       = in_data[39:8];
  assign resp_rx_time       = in_data[71:40];
  assign carrier_integrator = in_data[92:72];

  assign rr = remote_tx_stamp - remote_rx_stamp;
  assign t  = {ri[STAMP_W-1], ri} - {rr[STAMP_W-1], rr};

  assign status.frame_good = header_ok && !overlong && (byte_index >= IDX_W'(MIN_FRAME));

  assign fail_inc = fail_count + 1'b1;
  assign give_up  = (fail_inc >= cfg.max_attempts) || (fail_inc == '0);

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_op)
      MUL_P: begin
        mul_a = {{(MUL_W-INTEG_W){integ[INTEG_W-1]}}, integ};
        mul_b = {cfg.ratio_gain[31], cfg.ratio_gain};
      end
      MUL_C0: begin
        mul_a = {rr[STAMP_W-1], rr};
        mul_b = {1'b0, prod[31:0]};
      end
      MUL_C1: begin
        mul_a = {rr[STAMP_W-1], rr};
        mul_b = {{(MUL_W-INTEG_W){p_hi[INTEG_W-1]}}, p_hi};
      end
      MUL_D0: begin
        mul_a = {1'b0, acc[31:0]};
        mul_b = {1'b0, cfg.distance_scale};
      end
      MUL_D1: begin
        mul_a = {1'b0, acc[63:32]};
        mul_b = {1'b0, cfg.distance_scale};
      end
      MUL_D2: begin
        mul_a = {7'd0, acc[ACC_W-1:64]};
        mul_b = {1'b0, cfg.distance_scale};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.mul_op == MUL_C0) begin
      p_hi <= prod[52:32];
    end
    case (cmd.acc_op)
      ACC_INIT:   acc  <= {t[STAMP_W], t, 56'd0};
      ACC_ADD_LO: acc  <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      ACC_ADD_HI: acc  <= acc + {prod[57:0], 32'd0};
      DACC_LOAD:  dacc <= {1'b0, prod[63:0]};
      // fold in the next partial product, shifting the running sum one word down
      DACC_ADD:   dacc <= {32'd0, dacc[DACC_W-1:32]} + {1'b0, prod[63:0]};
      default: ;
    endcase
    if (cmd.byte_we) begin
      ri    <= resp_rx_time - poll_tx_time;
      integ <= carrier_integrator;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= '0;
      header_ok       <= 1'b1;
      overlong        <= 1'b0;
      remote_rx_stamp <= '0;
      remote_tx_stamp <= '0;
      seq_counter     <= '0;
      fail_count      <= '0;
    end else if (cmd.result_we) begin
      byte_index      <= '0;
      header_ok       <= 1'b1;
      overlong        <= 1'b0;
      remote_rx_stamp <= '0;
      remote_tx_stamp <= '0;
      seq_counter     <= seq_counter + 1'b1;
      if (cmd.kind == KIND_OK) begin
        fail_count <= '0;
      end else begin
        fail_count <= give_up ? '0 : fail_inc;
      end
    end else if (cmd.byte_we) begin
      if (byte_index >= IDX_W'(FRAME_BYTES)) begin
        overlong <= 1'b1;
      end else begin
        if ((byte_index < IDX_W'(HEADER_BYTES)) && (byte_index != IDX_W'(SEQ_POS)) &&
            (rx_byte != resp_header_byte(byte_index[3:0]))) begin
          header_ok <= 1'b0;
        end
        for (int k = 0; k < STAMP_BYTES; k++) begin
          if (byte_index == IDX_W'(RX_STAMP_POS + k)) begin
            remote_rx_stamp[8*k +: 8] <= rx_byte;
          end
          if (byte_index == IDX_W'(TX_STAMP_POS + k)) begin
            remote_tx_stamp[8*k +: 8] <= rx_byte;
          end
        end
        byte_index <= byte_index + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.result_we) begin
      out_seq <= seq_counter;
      if (cmd.kind == KIND_OK) begin
        out_status <= STATUS_DISTANCE;
        if (acc[ACC_W-1]) begin
          out_dist    <= '0;
          out_clamped <= 1'b1;
        end else if (|dacc[DACC_W-1:40]) begin
          out_dist    <= '1;
          out_clamped <= 1'b1;
        end else begin
          out_dist    <= dacc[39:24];
          out_clamped <= 1'b0;
        end
      end else begin
        out_dist    <= '0;
        out_clamped <= 1'b0;
        if (give_up) begin
          out_status <= STATUS_GAVE_UP;
        end else if (cmd.kind == KIND_TIMEOUT) begin
          out_status <= STATUS_TIMEOUT;
        end else begin
          out_status <= STATUS_MISMATCH;
        end
      end
    end
  end

  assign res_data   = {7'd0, out_seq, out_clamped, out_dist};
  assign res_status = out_status;

endmodule

>>> hw/rtl/twr_ctrl.sv
// ----------------------------------------------------------------------------
// Ranging controller
// Sequences byte intake, the distance calculation and the result handoff.
// ----------------------------------------------------------------------------
`include "twr_response_ranging_assert.svh"

module twr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                s_tuser,
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  twr_pkg::dp_status_t status,
  output twr_pkg::ctrl_cmd_t  cmd
);
  import twr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P,
    ST_C0,
    ST_C1,
    ST_A1,
    ST_D0,
    ST_D1,
    ST_D2,
    ST_DF,
    ST_RES
  } state_t;

  state_t state;
  kind_t  kind;
  logic   in_acc;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd.byte_we   = 1'b0;
    cmd.mul_op    = MUL_P;
    cmd.acc_op    = ACC_HOLD;
    cmd.result_we = 1'b0;
    cmd.kind      = kind;
    case (state)
      ST_IDLE: cmd.byte_we = in_acc && (s_tuser == CMD_BYTE);
      ST_P:    cmd.acc_op  = ACC_INIT;
      ST_C0:   cmd.mul_op  = MUL_C0;
      ST_C1: begin
        cmd.mul_op = MUL_C1;
        cmd.acc_op = ACC_ADD_LO;
      end
      ST_A1:   cmd.acc_op  = ACC_ADD_HI;
      ST_D0:   cmd.mul_op  = MUL_D0;
      ST_D1: begin
        cmd.mul_op = MUL_D1;
        cmd.acc_op = DACC_LOAD;
      end
      ST_D2: begin
        cmd.mul_op = MUL_D2;
        cmd.acc_op = DACC_ADD;
      end
      ST_DF:   cmd.acc_op    = DACC_ADD;
      ST_RES:  cmd.result_we = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      kind     <= KIND_OK;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.result_we) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_tuser == CMD_TIMEOUT) begin
              kind  <= KIND_TIMEOUT;
              state <= ST_RES;
            end else if (s_tlast) begin
              kind  <= KIND_OK;
              state <= ST_P;
            end
          end
        end
        ST_P: begin
          if (status.frame_good) begin
            state <= ST_C0;
          end else begin
            kind  <= KIND_MISMATCH;
            state <= ST_RES;
          end
        end
        ST_C0: state <= ST_C1;
        ST_C1: state <= ST_A1;
        ST_A1: state <= ST_D0;
        ST_D0: state <= ST_D1;
        ST_D1: state <= ST_D2;
        ST_D2: state <= ST_DF;
        ST_DF: state <= ST_RES;
        ST_RES: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TWR_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == ST_IDLE && !m_tvalid))
  `TWR_ASSERT(a_result_from_res, $rose(m_tvalid) |-> $past(state == ST_RES))
  `TWR_ASSERT(a_last_starts_calc, (in_acc && s_tuser == CMD_BYTE && s_tlast) |=> state == ST_P)
  `TWR_ASSERT(a_timeout_reports, (in_acc && s_tuser == CMD_TIMEOUT) |=> state == ST_RES)

endmodule

>>> hw/rtl/twr_response_ranging.sv
// ----------------------------------------------------------------------------
// Two-way ranging response checker, initiator side
// Checks response frames byte by byte and turns the stamps into a distance.
// ----------------------------------------------------------------------------
// Input stream: one item per frame byte (s_tuser = 0) or one timeout/error
// item (s_tuser = 1). s_tlast marks the final byte; the poll and response
// times and the carrier integrator are sampled with that byte.
// Output stream: one result per ended attempt (last byte or timeout), with
// the status code in m_tuser and distance, clamp flag and poll sequence in
// m_tdata.
// Ordinary bytes are taken one per cycle while the controller is idle.
// After the last byte of a good frame the shared 33x33 multiplier runs six
// products in sequence before the result register loads; a bad frame skips
// them, as does a timeout. No new item is taken while a calculation runs.
// The result sits in an output register: bytes keep flowing while it waits,
// but the next result holds until m_tready takes the current one.
// Reset restores the register defaults, zeroes the sequence and fail count
// and starts a fresh frame; no clearing pass is needed. The user must write
// configuration over the APB-style port while the block is idle, unenforced.
// ----------------------------------------------------------------------------
module twr_response_ranging #(
  parameter int FRAME_BYTES  = twr_pkg::FRAME_BYTES_DEF,
  parameter int HEADER_BYTES = twr_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // rx_byte[7:0], poll_tx_time[39:8], resp_rx_time[71:40],
  // carrier_integrator[92:72], zero pad
  input  logic [twr_pkg::S_TDATA_W-1:0] s_tdata,
  // cmd
  input  logic                          s_tuser,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // range_cm[15:0], clamped[16], poll_seq[24:17], zero pad
  output logic [twr_pkg::M_TDATA_W-1:0] m_tdata,
  // status
  output logic [twr_pkg::STATUS_W-1:0]  m_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [twr_pkg::CFG_AW-1:0]    paddr,
  input  logic [twr_pkg::CFG_DW-1:0]    pwdata,
  output logic [twr_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);
  import twr_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  twr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  twr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (dp_status),
    .cmd      (cmd)
  );

  twr_dp #(
    .FRAME_BYTES  (FRAME_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .in_data    (s_tdata),
    .status     (dp_status),
    .res_data   (m_tdata),
    .res_status (m_tuser)
  );

endmodule
